>>> rtl/pfx_eval_pkg.sv
// ----------------------------------------------------------------------------
// Postfix expression evaluator package
// Character codes, error flag positions and defaults shared by the evaluator.
// ----------------------------------------------------------------------------
package pfx_eval_pkg;

	localparam int STACK_DEPTH_DEFAULT = 64;

	localparam int WORD_W = 32;
	localparam int CHAR_W = 8;
	localparam int ERR_W  = 3;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
	localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;

	localparam logic [WORD_W-1:0] EMPTY_POP_VALUE = 32'd36;

	localparam int ERR_UNDERFLOW = 0;
	localparam int ERR_OVERFLOW  = 1;
	localparam int ERR_DIVZERO   = 2;

endpackage

>>> rtl/postfix_expression_evaluator.sv
// ----------------------------------------------------------------------------
// Postfix expression evaluator
// Evaluates a reverse Polish expression fed one ASCII character per transaction.
// ----------------------------------------------------------------------------
// Each character is one input transaction, and the block stalls its input until
// the character is fully processed. A digit that does not end the expression
// is taken in the idle state alone. A space or the first operator after a
// number adds a step to push the number. An operator runs through the accepting
// step, two pops through the registered stack memory, a step in the shared adder
// or multiplier, and a push. A divide by a nonzero divisor runs through a
// radix-2 divider that retires one quotient bit per cycle, then a sign fix,
// before the push. The last character adds a final pop and a step that loads
// the output register, and it waits there while a previous result has not yet
// been taken. The stack needs no clearing pass after reset, since only entries
// below the fill count are read.
module postfix_expression_evaluator #(
	parameter int STACK_DEPTH = pfx_eval_pkg::STACK_DEPTH_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [pfx_eval_pkg::CHAR_W-1:0]      character,
	input  logic                                 is_last,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [pfx_eval_pkg::WORD_W-1:0] value,
	output logic [pfx_eval_pkg::ERR_W-1:0]       error_flags
);
	import pfx_eval_pkg::*;

	localparam int AW     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW     = $clog2(STACK_DEPTH + 1);
	localparam int STEP_W = $clog2(WORD_W);

	typedef enum logic [9:0] {
		S_IDLE    = 10'b00_0000_0001,
		S_PUSHNUM = 10'b00_0000_0010,
		S_POPR    = 10'b00_0000_0100,
		S_POPL    = 10'b00_0000_1000,
		S_EXEC    = 10'b00_0001_0000,
		S_DIV     = 10'b00_0010_0000,
		S_DIVFIX  = 10'b00_0100_0000,
		S_PUSHRES = 10'b00_1000_0000,
		S_FINPOP  = 10'b01_0000_0000,
		S_FINCAP  = 10'b10_0000_0000
	} state_t;

	state_t              state_q;
	logic [CW-1:0]       count_q;
	logic [WORD_W-1:0]   acc_q;
	logic                in_number_q;
	logic [ERR_W-1:0]    err_q;
	logic [CHAR_W-1:0]   char_q;
	logic                last_q;
	logic                rmem_q;
	logic                lmem_q;
	logic [WORD_W-1:0]   right_q;
	logic [WORD_W-1:0]   res_q;
	logic [WORD_W-1:0]   rem_q;
	logic [WORD_W-1:0]   quo_q;
	logic [WORD_W-1:0]   dvs_q;
	logic [STEP_W-1:0]   step_q;
	logic                neg_q;
	logic                out_valid_q;
	logic [WORD_W-1:0]   out_value_q;
	logic [ERR_W-1:0]    out_err_q;

	logic [WORD_W-1:0]   mem [STACK_DEPTH];
	logic [WORD_W-1:0]   rd_data_q;

	logic                push_en;
	logic                push_full;
	logic                wr_en;
	logic [WORD_W-1:0]   wr_data;
	logic                pop_en;
	logic                pop_empty;
	logic                rd_en;
	logic [CW-1:0]       cnt_dec;
	logic                in_digit;
	logic                q_digit;
	logic [WORD_W-1:0]   digit_val;
	logic [WORD_W-1:0]   acc_next;
	logic [WORD_W-1:0]   left_val;
	logic [WORD_W-1:0]   right_val;
	logic [WORD_W-1:0]   prod;
	logic [WORD_W-1:0]   abs_left;
	logic [WORD_W-1:0]   abs_right;
	logic [WORD_W:0]     div_shift;
	logic [WORD_W:0]     div_diff;
	logic                out_free;
	state_t              done_next;

	assign in_stall    = (state_q != S_IDLE);
	assign out_valid   = out_valid_q;
	assign value       = out_value_q;
	assign error_flags = out_err_q;

	assign in_digit  = (character >= CH_ZERO) && (character <= CH_NINE);
	assign q_digit   = (char_q >= CH_ZERO) && (char_q <= CH_NINE);
	assign digit_val = {{(WORD_W - CHAR_W){1'b0}}, character - CH_ZERO};
	assign acc_next  = in_number_q
		? ({acc_q[WORD_W-4:0], 3'b000} + {acc_q[WORD_W-2:0], 1'b0} + digit_val)
		: digit_val;

	assign push_en   = (state_q == S_PUSHNUM) || (state_q == S_PUSHRES);
	assign push_full = (count_q == CW'(STACK_DEPTH));
	assign wr_en     = push_en && !push_full;
	assign wr_data   = (state_q == S_PUSHNUM) ? acc_q : res_q;

	assign pop_en    = (state_q == S_POPR) || (state_q == S_POPL) || (state_q == S_FINPOP);
	assign pop_empty = (count_q == '0);
	assign rd_en     = pop_en && !pop_empty;
	assign cnt_dec   = count_q - CW'(1);

	assign right_val = rmem_q ? rd_data_q : EMPTY_POP_VALUE;
	assign left_val  = lmem_q ? rd_data_q : EMPTY_POP_VALUE;
	assign prod      = left_val * right_q;
	assign abs_left  = left_val[WORD_W-1] ? (WORD_W'(0) - left_val) : left_val;
	assign abs_right = right_q[WORD_W-1] ? (WORD_W'(0) - right_q) : right_q;

	assign div_shift = {rem_q, quo_q[WORD_W-1]};
	assign div_diff  = div_shift - {1'b0, dvs_q};

	assign out_free  = !out_valid_q || !out_stall;
	assign done_next = last_q ? S_FINPOP : S_IDLE;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[count_q[AW-1:0]] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[cnt_dec[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			char_q <= character;
			last_q <= is_last;
		end
		if (state_q == S_POPR) begin
			rmem_q <= !pop_empty;
		end
		if (state_q == S_POPL) begin
			lmem_q  <= !pop_empty;
			right_q <= right_val;
		end
		if (state_q == S_FINPOP) begin
			lmem_q <= !pop_empty;
		end
		if (state_q == S_EXEC) begin
			dvs_q  <= abs_right;
			quo_q  <= abs_left;
			rem_q  <= '0;
			step_q <= '0;
			neg_q  <= left_val[WORD_W-1] ^ right_q[WORD_W-1];
			case (char_q)
				CH_PLUS:  res_q <= left_val + right_q;
				CH_MINUS: res_q <= left_val - right_q;
				CH_STAR:  res_q <= prod;
				default:  res_q <= '0;
			endcase
		end
		if (state_q == S_DIV) begin
			step_q <= step_q + STEP_W'(1);
			if (!div_diff[WORD_W]) begin
				rem_q <= div_diff[WORD_W-1:0];
				quo_q <= {quo_q[WORD_W-2:0], 1'b1};
			end else begin
				rem_q <= div_shift[WORD_W-1:0];
				quo_q <= {quo_q[WORD_W-2:0], 1'b0};
			end
		end
		if (state_q == S_DIVFIX) begin
			res_q <= neg_q ? (WORD_W'(0) - quo_q) : quo_q;
		end
		if (state_q == S_FINCAP && out_free) begin
			out_value_q <= left_val;
			out_err_q   <= err_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			acc_q       <= '0;
			in_number_q <= 1'b0;
			err_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FINCAP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (wr_en) begin
				count_q <= count_q + CW'(1);
			end else if (push_en) begin
				err_q[ERR_OVERFLOW] <= 1'b1;
			end
			if (rd_en) begin
				count_q <= cnt_dec;
			end else if (pop_en) begin
				err_q[ERR_UNDERFLOW] <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (in_digit) begin
							acc_q       <= acc_next;
							in_number_q <= 1'b1;
							state_q     <= is_last ? S_PUSHNUM : S_IDLE;
						end else if (in_number_q) begin
							state_q <= S_PUSHNUM;
						end else if (character == CH_SPACE) begin
							state_q <= is_last ? S_FINPOP : S_IDLE;
						end else begin
							state_q <= S_POPR;
						end
					end
				end
				S_PUSHNUM: begin
					acc_q       <= '0;
					in_number_q <= 1'b0;
					if (q_digit || char_q == CH_SPACE) begin
						state_q <= done_next;
					end else begin
						state_q <= S_POPR;
					end
				end
				S_POPR: begin
					state_q <= S_POPL;
				end
				S_POPL: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					case (char_q)
						CH_PLUS, CH_MINUS, CH_STAR: begin
							state_q <= S_PUSHRES;
						end
						CH_SLASH: begin
							if (right_q == '0) begin
								err_q[ERR_DIVZERO] <= 1'b1;
								state_q            <= S_PUSHRES;
							end else begin
								state_q <= S_DIV;
							end
						end
						default: begin
							state_q <= done_next;
						end
					endcase
				end
				S_DIV: begin
					if (step_q == STEP_W'(WORD_W - 1)) begin
						state_q <= S_DIVFIX;
					end
				end
				S_DIVFIX: begin
					state_q <= S_PUSHRES;
				end
				S_PUSHRES: begin
					state_q <= done_next;
				end
				S_FINPOP: begin
					state_q <= S_FINCAP;
				end
				S_FINCAP: begin
					if (out_free) begin
						count_q     <= '0;
						acc_q       <= '0;
						in_number_q <= 1'b0;
						err_q       <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH))
		else $error("Stack fill count exceeds the stack depth.");

	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && is_last |=> in_stall)
		else $error("Last character did not start the final pop sequence.");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_FINCAP))
		else $error("Result transaction raised outside the output load step.");

	a_clear_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FINCAP && out_free |=> count_q == '0 && err_q == '0 && !in_number_q)
		else $error("Evaluator state not cleared after the final result.");
`endif

endmodule
